FILE: design/shpa_pkg.sv
// Shared types and constants of the shadow/highlight pixel adjust pipeline.
// Used by every module of the block; depends on nothing.
package shpa_pkg;

   // Field widths
   localparam int CH_W     = 8;
   localparam int PCT_W    = 7;
   localparam int TONE_W   = 9;
   localparam int CSR_W    = 9;
   localparam int Q_FRAC   = 16;
   localparam int LUMA_W   = Q_FRAC + 1;

   // Unity in Q1.16 and register limits
   localparam logic [LUMA_W-1:0] Q_ONE     = 17'd65536;
   localparam logic [TONE_W-1:0] TONE_MAX  = 9'd256;
   localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
   localparam logic [TONE_W-1:0] TONE_RST  = 9'd128;

   // Luma: weighted sum, then divide by 255000 through a reciprocal
   localparam int                 SUM_W        = 18;
   localparam logic [SUM_W-1:0]   LUMA_DEN     = 18'd255000;
   localparam int                 LUMA_RECIP_W = 23;
   localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 23'd4311810;
   localparam int                 LUMA_SHIFT   = 24;
   localparam int                 LUMA_PROD_W  = SUM_W + LUMA_RECIP_W;
   localparam int                 LUMA_CMP_W   = 36;

   // Mask divider: 25-bit dividend, 17 quotient bits, up to six bits per stage
   localparam int NUM_W           = 25;
   localparam int DIV_STEPS       = 17;
   localparam int DIV_STAGE_STEPS = 6;
   localparam int DIV_STAGES      = (DIV_STEPS + DIV_STAGE_STEPS - 1) / DIV_STAGE_STEPS;
   localparam int DIV_TOP_W       = NUM_W - DIV_STEPS;

   // Percent scaling: divide by 200 as a shift by 3 and a reciprocal of 25
   localparam int                   PCT_PROD_W = PCT_W + LUMA_W;
   localparam int                   DIV8_W     = PCT_PROD_W - 3;
   localparam int                   RECIP25_W  = 21;
   localparam logic [RECIP25_W-1:0] RECIP25    = 21'd1342178;
   localparam int                   RECIP25_SH = 25;

   // Register map
   typedef enum logic [1:0] {
      CSR_SHADOW    = 2'd0,
      CSR_HIGHLIGHT = 2'd1,
      CSR_TONAL     = 2'd2
   } csr_index_type;

   // Saturated settings
   typedef struct packed {
      logic [TONE_W-1:0] tonal;
      logic [PCT_W-1:0]  highlight;
      logic [PCT_W-1:0]  shadow;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type         pix;
      logic [LUMA_W-1:0] luma;
   } luma_item_type;

   typedef struct packed {
      pixel_type         pix;
      logic [LUMA_W-1:0] shadow_base;
      logic [LUMA_W-1:0] highlight_base;
   } mask_item_type;

endpackage

FILE: design/shpa_luma.sv
// Luma unit: BT.601 weighted sum and exact divide to Q1.16, three stages.
// Depends on shpa_pkg.
module shpa_luma (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  shpa_pkg::pixel_type     in_pix,
   output logic                    out_valid,
   input  logic                    out_ready,
   output shpa_pkg::luma_item_type out_item
);
   import shpa_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   pixel_type pix1_ff, pix2_ff, pix3_ff;
   logic [SUM_W-1:0]       sum1_in, sum1_ff, sum2_ff;
   logic [LUMA_PROD_W-1:0] prod;
   logic [LUMA_W-1:0]      est2_in, est2_ff;
   logic [LUMA_W:0]        est_inc;
   logic [LUMA_CMP_W-1:0]  trial, scaled;
   logic [LUMA_W-1:0]      luma3_in, luma3_ff;

   // Ready chain: a stage takes a request when empty or when it moves on
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: weighted sum of the channels
   assign sum1_in = SUM_W'(in_pix.red)   * SUM_W'(299)
                  + SUM_W'(in_pix.green) * SUM_W'(587)
                  + SUM_W'(in_pix.blue)  * SUM_W'(114);

   // Stage 2: estimate the quotient, low by at most one
   assign prod    = LUMA_PROD_W'(sum1_ff) * LUMA_PROD_W'(LUMA_RECIP);
   assign est2_in = prod[LUMA_SHIFT +: LUMA_W];

   // Stage 3: bump the estimate when the next multiple still fits
   always_comb begin
      est_inc  = {1'b0, est2_ff} + (LUMA_W+1)'(1);
      trial    = LUMA_CMP_W'(est_inc) * LUMA_CMP_W'(LUMA_DEN);
      scaled   = LUMA_CMP_W'({sum2_ff, {Q_FRAC{1'b0}}});
      luma3_in = (scaled >= trial) ? est_inc[LUMA_W-1:0] : est2_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         pix1_ff <= in_pix;
         sum1_ff <= sum1_in;
      end
      if (rdy2 && v1_ff) begin
         pix2_ff <= pix1_ff;
         sum2_ff <= sum1_ff;
         est2_ff <= est2_in;
      end
      if (rdy3 && v2_ff) begin
         pix3_ff  <= pix2_ff;
         luma3_ff <= luma3_in;
      end
   end

   assign out_valid     = v3_ff;
   assign out_item.pix  = pix3_ff;
   assign out_item.luma = luma3_ff;

   // Luma never exceeds unity
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (luma3_ff <= Q_ONE))
      else $error("luma above unity");

endmodule

FILE: design/shpa_div.sv
// Mask divider: forms the shadow and highlight dividends from luma and the
// tonal width and divides both by the tonal width, six quotient bits a stage (five in the last).
// Depends on shpa_pkg.
module shpa_div (
   input  logic                    clock,
   input  logic                    reset,
   input  shpa_pkg::cfg_type       cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  shpa_pkg::luma_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output shpa_pkg::mask_item_type out_item
);
   import shpa_pkg::*;

   typedef struct packed {
      logic [NUM_W-1:0]  num;
      logic [TONE_W-1:0] rem;
      logic [LUMA_W-1:0] quo;
   } div_lane_type;

   // Run one stage worth of restoring division steps
   function automatic div_lane_type div_run(div_lane_type a, logic [TONE_W-1:0] t,
                                            int first);
      div_lane_type      b;
      logic [TONE_W:0]   rr;
      logic [4:0]        idx;
      b = a;
      for (int i = 0; i < DIV_STAGE_STEPS; i++) begin
         if (first + i < DIV_STEPS) begin
            idx = 5'(DIV_STEPS - 1 - (first + i));
            rr  = {b.rem, b.num[idx]};
            if (rr >= {1'b0, t}) begin
               b.rem      = TONE_W'(rr - {1'b0, t});
               b.quo[idx] = 1'b1;
            end else begin
               b.rem = rr[TONE_W-1:0];
            end
         end
      end
      return b;
   endfunction

   logic [DIV_STAGES:0]   v_ff, v_in, take;
   logic [DIV_STAGES+1:0] rdy;
   pixel_type    pix_ff [0:DIV_STAGES];
   pixel_type    pix_in [0:DIV_STAGES];
   div_lane_type s_ff   [0:DIV_STAGES];
   div_lane_type s_in   [0:DIV_STAGES];
   div_lane_type h_ff   [0:DIV_STAGES];
   div_lane_type h_in   [0:DIV_STAGES];

   logic [LUMA_W-1:0] tone_q;
   logic [LUMA_W:0]   h_sum;
   logic [NUM_W-1:0]  s_num, h_num;

   // Dividends: shadow from (T - L), highlight from (L - 1 + T)
   always_comb begin
      tone_q = LUMA_W'({cfg.tonal, 8'b0});
      h_sum  = {1'b0, in_item.luma} + {1'b0, tone_q};
      s_num  = (in_item.luma < tone_q) ?
               NUM_W'({tone_q - in_item.luma, 8'b0}) : '0;
      h_num  = (h_sum > {1'b0, Q_ONE}) ?
               NUM_W'({h_sum - {1'b0, Q_ONE}, 8'b0}) : '0;
   end

   // Ready chain from the output back
   always_comb begin
      rdy[DIV_STAGES+1] = out_ready;
      for (int k = DIV_STAGES; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   // Next values of every stage
   always_comb begin
      v_in[0]   = in_valid;
      take[0]   = in_valid && rdy[0];
      pix_in[0] = in_item.pix;
      s_in[0]   = '{num: s_num, rem: {1'b0, s_num[NUM_W-1 -: DIV_TOP_W]}, quo: '0};
      h_in[0]   = '{num: h_num, rem: {1'b0, h_num[NUM_W-1 -: DIV_TOP_W]}, quo: '0};
      for (int k = 1; k <= DIV_STAGES; k++) begin
         v_in[k]   = v_ff[k-1];
         take[k]   = v_ff[k-1] && rdy[k];
         pix_in[k] = pix_ff[k-1];
         s_in[k]   = div_run(s_ff[k-1], cfg.tonal, (k-1) * DIV_STAGE_STEPS);
         h_in[k]   = div_run(h_ff[k-1], cfg.tonal, (k-1) * DIV_STAGE_STEPS);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            if (rdy[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
         if (take[k]) begin
            pix_ff[k] <= pix_in[k];
            s_ff[k]   <= s_in[k];
            h_ff[k]   <= h_in[k];
         end
      end
   end

   assign out_valid               = v_ff[DIV_STAGES];
   assign out_item.pix            = pix_ff[DIV_STAGES];
   assign out_item.shadow_base    = s_ff[DIV_STAGES].quo;
   assign out_item.highlight_base = h_ff[DIV_STAGES].quo;

endmodule

FILE: design/shpa_tone.sv
// Tone stages: square the mask bases, scale by the percent settings, and
// apply lift and compression to each channel with an upper clamp.
// Depends on shpa_pkg.
module shpa_tone (
   input  logic                    clock,
   input  logic                    reset,
   input  shpa_pkg::cfg_type       cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  shpa_pkg::mask_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output shpa_pkg::pixel_type     out_pix
);
   import shpa_pkg::*;

   localparam int SQ_W   = 2 * LUMA_W;
   localparam int R25_W  = DIV8_W + RECIP25_W;
   localparam int CHAN_W = 26;

   // Channel out = (c * comp + 255 * lift) >> 16, clamped to 255
   function automatic logic [CH_W-1:0] chan_adjust(logic [CH_W-1:0] c,
                                                   logic [LUMA_W-1:0] comp,
                                                   logic [LUMA_W-1:0] lift);
      logic [CHAN_W-1:0] v;
      v = CHAN_W'(c) * CHAN_W'(comp) + (CHAN_W'(lift) << 8) - CHAN_W'(lift);
      return (v[CHAN_W-1:Q_FRAC] > (CHAN_W-Q_FRAC)'(255)) ?
             CH_W'(255) : v[Q_FRAC +: CH_W];
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   pixel_type pix1_ff, pix2_ff, pix3_ff;
   logic [SQ_W-1:0]       s_sq, h_sq;
   logic [LUMA_W-1:0]     smask1_in, smask1_ff, hmask1_in, hmask1_ff;
   logic [PCT_PROD_W-1:0] sprod2_in, sprod2_ff, hprod2_in, hprod2_ff;
   logic [R25_W-1:0]      s_r25, h_r25;
   logic [LUMA_W-1:0]     lift3_in, lift3_ff, comp3_in, comp3_ff;
   pixel_type             pix4_in, pix4_ff;

   // Ready chain
   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: square the bases; zero tonal width gives zero masks
   always_comb begin
      s_sq      = SQ_W'(in_item.shadow_base) * SQ_W'(in_item.shadow_base);
      h_sq      = SQ_W'(in_item.highlight_base) * SQ_W'(in_item.highlight_base);
      smask1_in = (cfg.tonal == '0) ? '0 : s_sq[Q_FRAC +: LUMA_W];
      hmask1_in = (cfg.tonal == '0) ? '0 : h_sq[Q_FRAC +: LUMA_W];
   end

   // Stage 2: scale by percent
   assign sprod2_in = PCT_PROD_W'(cfg.shadow) * PCT_PROD_W'(smask1_ff);
   assign hprod2_in = PCT_PROD_W'(cfg.highlight) * PCT_PROD_W'(hmask1_ff);

   // Stage 3: divide by 200, form lift and compression
   always_comb begin
      s_r25    = R25_W'(sprod2_ff[PCT_PROD_W-1:3]) * R25_W'(RECIP25);
      h_r25    = R25_W'(hprod2_ff[PCT_PROD_W-1:3]) * R25_W'(RECIP25);
      lift3_in = s_r25[RECIP25_SH +: LUMA_W];
      comp3_in = Q_ONE - h_r25[RECIP25_SH +: LUMA_W];
   end

   // Stage 4: adjust each channel
   always_comb begin
      pix4_in.red   = chan_adjust(pix3_ff.red,   comp3_ff, lift3_ff);
      pix4_in.green = chan_adjust(pix3_ff.green, comp3_ff, lift3_ff);
      pix4_in.blue  = chan_adjust(pix3_ff.blue,  comp3_ff, lift3_ff);
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         pix1_ff   <= in_item.pix;
         smask1_ff <= smask1_in;
         hmask1_ff <= hmask1_in;
      end
      if (rdy2 && v1_ff) begin
         pix2_ff   <= pix1_ff;
         sprod2_ff <= sprod2_in;
         hprod2_ff <= hprod2_in;
      end
      if (rdy3 && v2_ff) begin
         pix3_ff  <= pix2_ff;
         lift3_ff <= lift3_in;
         comp3_ff <= comp3_in;
      end
      if (rdy4 && v3_ff) begin
         pix4_ff <= pix4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_pix   = pix4_ff;

endmodule

FILE: design/shadow_highlight_pixel_adjust.sv
// Top level of the shadow/highlight pixel adjust block: settings registers
// and the luma, divider and tone pipeline segments. Depends on shpa_pkg.
//
// Usage:
//   req_* carries one RGB pixel per request, rsp_* returns the adjusted pixel
//   in the same order. Both are valid/ready streams; a request moves on a
//   rising edge with tvalid and tready high.
//   csr_* writes one setting per request: index 0 shadow percent, 1
//   highlight percent, 2 tonal width. Percents, taken from the low seven
//   data bits, above 100 and tonal widths above 256 are stored saturated;
//   other indexes are dropped. Write settings only while no pixel is in flight.
//   A pixel passes from request to result through the luma unit (sum,
//   reciprocal multiply, correction), the divider (dividend setup and
//   three stages of six, six and five quotient bits) and the tone stages.
//   Throughput is one pixel per cycle while rsp_tready stays high.
//   Each stage holds its own valid bit, so when rsp_tready is low, the
//   empty stages still fill and req_tready drops only with all 11 full.
//   Reset empties the pipeline and loads shadow 0, highlight 0, tonal 128.
module shadow_highlight_pixel_adjust (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,    // blue_in [23:16], green_in [15:8], red_in [7:0]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,    // blue_out [23:16], green_out [15:8], red_out [7:0]
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [shpa_pkg::CSR_W-1:0]   csr_data
);
   import shpa_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   luma_item_type luma_item;
   mask_item_type mask_item;
   pixel_type     out_pix;
   logic          luma_valid, luma_ready, mask_valid, mask_ready;

   // Settings: store saturated values
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHADOW:
               cfg_in.shadow = (csr_data[PCT_W-1:0] > PCT_MAX) ?
                               PCT_MAX : csr_data[PCT_W-1:0];
            CSR_HIGHLIGHT:
               cfg_in.highlight = (csr_data[PCT_W-1:0] > PCT_MAX) ?
                                  PCT_MAX : csr_data[PCT_W-1:0];
            CSR_TONAL:
               cfg_in.tonal = (csr_data > TONE_MAX) ? TONE_MAX : csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{tonal: TONE_RST, highlight: '0, shadow: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   shpa_luma u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (pixel_type'(req_tdata)),
      .out_valid (luma_valid),
      .out_ready (luma_ready),
      .out_item  (luma_item)
   );

   shpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (luma_valid),
      .in_ready  (luma_ready),
      .in_item   (luma_item),
      .out_valid (mask_valid),
      .out_ready (mask_ready),
      .out_item  (mask_item)
   );

   shpa_tone u_tone (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mask_valid),
      .in_ready  (mask_ready),
      .in_item   (mask_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (out_pix)
   );

   assign rsp_tdata = out_pix;

   // A ready receiver keeps the whole pipeline open
   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input blocked while output is taken");

   // Input stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a held result");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result left after reset");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for shadow_highlight_pixel_adjust: random and directed pixels
// checked in order against a fixed-point tone predictor. Depends on shpa_pkg.
module tb;
   import shpa_pkg::*;

   localparam int          CLK_HALF   = 4;
   localparam int          PIPE_DEPTH = 11;
   localparam int          LONG_HOLD  = 60;
   localparam int          CYCLE_CAP  = 300000;
   localparam logic [1:0]  CSR_SPARE  = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   pixel_type   req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   pixel_type   rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [8:0]  csr_data   = '0;

   // Settings as the block should hold them, already saturated
   logic [PCT_W-1:0]  shade_pct = '0;
   logic [PCT_W-1:0]  bright_pct = '0;
   logic [TONE_W-1:0] tone_span = TONE_RST;

   pixel_type   pending_pixels[$];
   pixel_type   expected_pixels[$];
   logic        req_fire   = 1'b0;
   logic        steady     = 1'b0;
   int          src_gap    = 0;
   int          sink_gap   = 0;
   int          hold_asked = 0;
   int          hold_done  = 0;
   int          hold_count = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   shadow_highlight_pixel_adjust dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Scale one channel by the compression, add the lift, clamp to full scale
   function automatic logic [CH_W-1:0] scale_channel(input longint unsigned c,
         input longint unsigned comp, input longint unsigned lift);
      longint unsigned v;
      v = (c * comp + 255 * lift) >> 16;
      return (v > 255) ? 8'd255 : v[CH_W-1:0];
   endfunction

   // Expected output pixel for one input pixel under the current settings
   function automatic pixel_type tone_adjust_pixel(input pixel_type px);
      longint unsigned r, g, b, t, luma, s, h, smask, hmask, lift, comp;
      pixel_type res;
      r = 64'(px.red);
      g = 64'(px.green);
      b = 64'(px.blue);
      t = 64'(tone_span);
      luma = ((299 * r + 587 * g + 114 * b) * 65536) / 255000;
      smask = 0;
      hmask = 0;
      if (t != 0) begin
         s = 0;
         h = 0;
         if (65536 * t > 256 * luma) s = (65536 * t - 256 * luma) / t;
         if (luma + 256 * t > 65536) h = (256 * (luma + 256 * t - 65536)) / t;
         if (s > 65536) s = 65536;
         if (h > 65536) h = 65536;
         smask = (s * s) >> 16;
         hmask = (h * h) >> 16;
      end
      lift = (64'(shade_pct) * smask) / 200;
      comp = 65536 - (64'(bright_pct) * hmask) / 200;
      res.red   = scale_channel(r, comp, lift);
      res.green = scale_channel(g, comp, lift);
      res.blue  = scale_channel(b, comp, lift);
      return res;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.red   = CH_W'($urandom_range(0, 255));
      px.green = CH_W'($urandom_range(0, 255));
      px.blue  = CH_W'($urandom_range(0, 255));
      // Gray pixels sweep the luma range evenly
      if ($urandom_range(0, 4) == 0) begin
         px.green = px.red;
         px.blue  = px.red;
      end
      return px;
   endfunction

   // Offer pixels from the pending queue, with random idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // hold the current request until it is taken
      end else if (src_gap > 0) begin
         src_gap    <= src_gap - 1;
         req_tvalid <= 1'b0;
      end else if (pending_pixels.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
         src_gap    <= $urandom_range(1, 8) - 1;
         req_tvalid <= 1'b0;
      end else begin
         req_tvalid <= 1'b1;
         req_tdata  <= pending_pixels.pop_front();
      end
   end

   // Drive the result ready: long hold-offs on request, else random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_done != hold_asked) begin
         if (hold_count >= LONG_HOLD) begin
            hold_count <= 0;
            hold_done  <= hold_done + 1;
            rsp_tready <= 1'b1;
         end else begin
            hold_count <= hold_count + 1;
            rsp_tready <= 1'b0;
         end
      end else if (sink_gap > 0) begin
         sink_gap   <= sink_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
         sink_gap   <= $urandom_range(1, 8) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Record accepted pixels and check each result against the oldest one
   always @(posedge clock) begin
      pixel_type want;
      req_fire <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_pixels.push_back(tone_adjust_pixel(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata.red !== want.red) begin
                  $display("%0t: red mismatch, expected %0d, actual %0d",
                           $time, want.red, rsp_tdata.red);
                  error_count++;
               end
               if (rsp_tdata.green !== want.green) begin
                  $display("%0t: green mismatch, expected %0d, actual %0d",
                           $time, want.green, rsp_tdata.green);
                  error_count++;
               end
               if (rsp_tdata.blue !== want.blue) begin
                  $display("%0t: blue mismatch, expected %0d, actual %0d",
                           $time, want.blue, rsp_tdata.blue);
                  error_count++;
               end
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Write one setting and mirror its saturation in the predictor
   task automatic write_setting(input logic [1:0] idx, input logic [8:0] value);
      logic [PCT_W-1:0] pct;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      pct = value[PCT_W-1:0];
      case (idx)
         CSR_SHADOW:    shade_pct  = (pct > PCT_MAX) ? PCT_MAX : pct;
         CSR_HIGHLIGHT: bright_pct = (pct > PCT_MAX) ? PCT_MAX : pct;
         CSR_TONAL:     tone_span  = (value > TONE_MAX) ? TONE_MAX : value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [8:0] shadow, input logic [8:0] highlight,
         input logic [8:0] tonal);
      write_setting(CSR_SHADOW, shadow);
      write_setting(CSR_HIGHLIGHT, highlight);
      write_setting(CSR_TONAL, tonal);
   endtask

   // Wait until every pixel was taken and every result came back
   task automatic wait_idle();
      @(posedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 1) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      repeat (count) pending_pixels.push_back(random_pixel());
   endtask

   task automatic queue_directed();
      pending_pixels.push_back('{blue: 8'd0,   green: 8'd0,   red: 8'd0});
      pending_pixels.push_back('{blue: 8'd255, green: 8'd255, red: 8'd255});
      pending_pixels.push_back('{blue: 8'd0,   green: 8'd0,   red: 8'd255});
      pending_pixels.push_back('{blue: 8'd0,   green: 8'd255, red: 8'd0});
      pending_pixels.push_back('{blue: 8'd255, green: 8'd0,   red: 8'd0});
      pending_pixels.push_back('{blue: 8'd64,  green: 8'd64,  red: 8'd64});
      pending_pixels.push_back('{blue: 8'd128, green: 8'd128, red: 8'd128});
      pending_pixels.push_back('{blue: 8'd192, green: 8'd192, red: 8'd192});
      pending_pixels.push_back('{blue: 8'h55,  green: 8'hAA,  red: 8'h55});
      pending_pixels.push_back('{blue: 8'hAA,  green: 8'h55,  red: 8'hAA});
      pending_pixels.push_back('{blue: 8'd1,   green: 8'd1,   red: 8'd1});
      pending_pixels.push_back('{blue: 8'd254, green: 8'd254, red: 8'd254});
   endtask

   function automatic logic [8:0] random_percent();
      case ($urandom_range(0, 4))
         0: return 9'd0;
         1: return 9'd100;
         2: return 9'($urandom_range(101, 511));
         default: return 9'($urandom_range(0, 100));
      endcase
   endfunction

   function automatic logic [8:0] random_tonal();
      case ($urandom_range(0, 4))
         0: return 9'd0;
         1: return 9'd256;
         2: return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(1, 255));
      endcase
   endfunction

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Reset settings, then full strength at full tonal width
      queue_directed();
      wait_idle();
      apply_settings(9'd100, 9'd100, 9'd256);
      queue_directed();
      wait_idle();

      // Zero tonal width passes pixels through
      write_setting(CSR_TONAL, 9'd0);
      queue_random(30);
      wait_idle();

      // Out-of-range values saturate (percents from their low seven bits); the spare index is dropped
      apply_settings(9'h1FF, 9'd101, 9'd511);
      write_setting(CSR_SPARE, 9'h1FF);
      queue_random(20);
      wait_idle();
      apply_settings(9'd200, 9'd127, 9'd300);
      write_setting(CSR_SPARE, 9'd0);
      queue_random(20);
      wait_idle();

      // Long receiver hold-off while the sender keeps offering
      apply_settings(9'd50, 9'd75, 9'd128);
      hold_asked = hold_asked + 1;
      queue_random(50);
      wait_idle();

      // Random settings, extremes favored
      repeat (5) begin
         apply_settings(random_percent(), random_percent(), random_tonal());
         queue_random(40);
         wait_idle();
      end

      // Closing stretch at full rate on both sides
      apply_settings(9'd30, 9'd60, 9'd200);
      steady = 1'b1;
      queue_random(60);
      wait_idle();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
